// ===== rtl/fvc_pkg.sv =====
package fvc_pkg;

  localparam int WordW = 32;
  localparam int DblW = 64;
  localparam int CountW = 13;
  localparam int CfgIdxW = 2;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONFINITE = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_DIMS = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_EXP_DIMS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_NORM_EN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LOW = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HIGH = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] canon;
    logic             last;
    logic             nonfinite;
  } item_t;

  // Number of leading zeros of a 24-bit significand (24 when it is zero).
  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] z;
    z = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) begin
        z = 5'(23 - i);
      end
    end
    return z;
  endfunction

endpackage

// ===== rtl/fvc_square.sv =====
module fvc_square (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [fvc_pkg::WordW-1:0] in_word,
  input  logic                      in_last,
  output fvc_pkg::item_t            item_o,
  output logic [fvc_pkg::DblW-1:0]  sq_o
);
  import fvc_pkg::*;

  logic [7:0]  exp_f;
  logic [23:0] mant;
  logic [4:0]  lz;
  item_t       s1_nxt;
  item_t       s1_r;
  item_t       s2_r;
  logic [23:0] mn_r;
  logic [11:0] eb_r;
  logic        zero_r;
  logic [47:0] prod;
  logic [10:0] eb_fin;
  logic [51:0] frac;
  logic [DblW-1:0] sq_r;

  always_comb begin
    exp_f = in_word[30:23];
    mant = {(exp_f != 8'd0), in_word[22:0]};
    lz = lzc24(mant);
    s1_nxt.valid = in_valid;
    s1_nxt.canon = (in_word == 32'h8000_0000) ? '0 : in_word;
    s1_nxt.last = in_last;
    s1_nxt.nonfinite = (exp_f == 8'hFF);
  end

  // The square of a widened binary32 value is exact in binary64 and always normal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r.valid <= s1_nxt.valid;
      s2_r.valid <= s1_r.valid;
    end
    if (adv) begin
      s1_r.canon <= s1_nxt.canon;
      s1_r.last <= s1_nxt.last;
      s1_r.nonfinite <= s1_nxt.nonfinite;
      mn_r <= mant << lz;
      zero_r <= (lz == 5'd24) || s1_nxt.nonfinite;
      if (exp_f == 8'd0) begin
        eb_r <= 12'd771 - {6'd0, lz, 1'b0};
      end else begin
        eb_r <= 12'd769 + {3'd0, exp_f, 1'b0} - {6'd0, lz, 1'b0};
      end
      s2_r.canon <= s1_r.canon;
      s2_r.last <= s1_r.last;
      s2_r.nonfinite <= s1_r.nonfinite;
      sq_r <= zero_r ? '0 : {1'b0, eb_fin, frac};
    end
  end

  always_comb begin
    prod = mn_r * mn_r;
    eb_fin = eb_r[10:0] + {10'd0, prod[47]};
    frac = prod[47] ? {prod[46:0], 5'd0} : {prod[45:0], 6'd0};
  end

  assign item_o = s2_r;
  assign sq_o = sq_r;

endmodule

// ===== rtl/fvc_add64.sv =====
module fvc_add64 (
  input  logic [fvc_pkg::DblW-1:0] a,
  input  logic [fvc_pkg::DblW-1:0] b,
  output logic [fvc_pkg::DblW-1:0] y
);
  import fvc_pkg::*;

  // Adds two non-negative normal or zero binary64 values, round to nearest even.
  logic [DblW-1:0] big;
  logic [DblW-1:0] sml;
  logic [10:0]     ea;
  logic [10:0]     eb;
  logic [10:0]     d;
  logic [55:0]     bx;
  logic [55:0]     sh;
  logic            st;
  logic [56:0]     s;
  logic [55:0]     n;
  logic [10:0]     e;
  logic            inc;
  logic [53:0]     mr;

  always_comb begin
    big = (a[62:0] >= b[62:0]) ? a : b;
    sml = (a[62:0] >= b[62:0]) ? b : a;
    ea = big[62:52];
    eb = sml[62:52];
    d = ea - eb;
    bx = {1'b1, sml[51:0], 3'b000};
    if (d >= 11'd56) begin
      sh = 56'd1;
    end else begin
      st = |(bx & ~({56{1'b1}} << d[5:0]));
      sh = bx >> d[5:0];
      sh[0] = sh[0] | st;
    end
    st = 1'b0;
    s = {1'b0, 1'b1, big[51:0], 3'b000} + {1'b0, sh};
    if (s[56]) begin
      n = {s[56:2], s[1] | s[0]};
      e = ea + 11'd1;
    end else begin
      n = s[55:0];
      e = ea;
    end
    inc = n[2] & (n[1] | n[0] | n[3]);
    mr = {1'b0, n[55:3]} + {53'd0, inc};
    if (eb == 11'd0) begin
      y = big;
    end else if (mr[53]) begin
      y = {1'b0, e + 11'd1, 52'd0};
    end else begin
      y = {1'b0, e, mr[51:0]};
    end
  end

endmodule

// ===== rtl/float_vector_canonicalize_norm_check_unit.sv =====
// Channel | Ports                                                | Direction
// input   | in_valid, in_stall, in_element_bits, in_last_element | item in
// result  | out_valid, out_stall, out_canonical_word, ...        | item out
// config  | cfg_wr_en, cfg_index, cfg_data                       | register write
// One item is accepted per cycle unless stalled; registers: s1, s2, stage 3, output.
// The binary64 accumulate is one combinational add, which sets the one-item rate.
// Synchronous reset clears the pipeline and the running sum and loads config defaults.
// A stalled result holds the whole pipeline, so in_stall follows the output register.
module float_vector_canonicalize_norm_check_unit #(
  parameter int MAX_DIMS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fvc_pkg::WordW-1:0]   in_element_bits,
  input  logic                        in_last_element,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fvc_pkg::WordW-1:0]   out_canonical_word,
  output logic                        out_is_final,
  output logic [1:0]                  out_status,
  input  logic                        cfg_wr_en,
  input  logic [fvc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fvc_pkg::DblW-1:0]    cfg_data
);
  import fvc_pkg::*;

  localparam logic [16:0] MaxDimsL = 17'(MAX_DIMS);

  logic              adv;
  item_t             it2;
  logic [DblW-1:0]   sq2;
  logic [DblW-1:0]   base;
  logic [DblW-1:0]   sum_nxt;
  logic [DblW-1:0]   sum_r;
  logic [CountW-1:0] cnt_base;
  logic [CountW-1:0] cnt_nxt;
  logic [CountW-1:0] cnt_r;
  logic              bad_nxt;
  logic              bad_r;
  logic              clr_r;
  logic              v3_r;
  logic [WordW-1:0]  canon3_r;
  logic              last3_r;
  logic              dim_bad3_r;
  logic              bad3_r;
  logic [CountW-1:0] exp_dims_r;
  logic              norm_en_r;
  logic [DblW-1:0]   low_r;
  logic [DblW-1:0]   high_r;
  logic              low_nan;
  logic              high_nan;
  logic              lt_low;
  logic              gt_high;
  logic [1:0]        status_nxt;
  logic              out_valid_r;
  logic [WordW-1:0]  out_word_r;
  logic              out_final_r;
  logic [1:0]        out_status_r;

  assign adv = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  fvc_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_word  (in_element_bits),
    .in_last  (in_last_element),
    .item_o   (it2),
    .sq_o     (sq2)
  );

  fvc_add64 u_add (
    .a (base),
    .b (sq2),
    .y (sum_nxt)
  );

  always_comb begin
    base = clr_r ? '0 : sum_r;
    cnt_base = clr_r ? '0 : cnt_r;
    cnt_nxt = (cnt_base == CountMax) ? cnt_base : cnt_base + 1'b1;
    bad_nxt = (!clr_r && bad_r) || it2.nonfinite;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_dims_r <= 13'd1;
      norm_en_r <= 1'b0;
      low_r <= 64'h3FF0_0000_0000_0000;
      high_r <= 64'h3FF0_0000_0000_0000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_EXP_DIMS: exp_dims_r <= cfg_data[CountW-1:0];
        REG_NORM_EN:  norm_en_r <= cfg_data[0];
        REG_LOW:      low_r <= cfg_data;
        REG_HIGH:     high_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      bad_r <= 1'b0;
      clr_r <= 1'b1;
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= it2.valid;
      if (it2.valid) begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        bad_r <= bad_nxt;
        clr_r <= it2.last;
      end
    end
    if (adv) begin
      canon3_r <= it2.canon;
      last3_r <= it2.last;
      dim_bad3_r <= (cnt_nxt != exp_dims_r) || ({4'd0, cnt_nxt} > MaxDimsL);
      bad3_r <= bad_nxt;
    end
  end

  // The sum is never negative, so bound tests reduce to unsigned compares.
  always_comb begin
    low_nan = (low_r[62:52] == 11'h7FF) && (low_r[51:0] != 52'd0);
    high_nan = (high_r[62:52] == 11'h7FF) && (high_r[51:0] != 52'd0);
    lt_low = !low_nan && !low_r[63] && (sum_r < low_r);
    if (high_nan) begin
      gt_high = 1'b0;
    end else if (high_r[63]) begin
      gt_high = (sum_r[62:0] != 63'd0) || (high_r[62:0] != 63'd0);
    end else begin
      gt_high = sum_r > high_r;
    end
    if (!last3_r) begin
      status_nxt = ST_OK;
    end else if (dim_bad3_r) begin
      status_nxt = ST_DIMS;
    end else if (bad3_r) begin
      status_nxt = ST_NONFINITE;
    end else if (norm_en_r && (lt_low || gt_high)) begin
      status_nxt = ST_NORM;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
    if (adv) begin
      out_word_r <= canon3_r;
      out_final_r <= last3_r;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_canonical_word = out_word_r;
  assign out_is_final = out_final_r;
  assign out_status = out_status_r;

  a_status_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_final_r |-> out_status_r == ST_OK)
    else $error("status set on a result that does not close the vector");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && it2.valid && it2.last |=> clr_r)
    else $error("running state not marked for clearing after the last item");

  a_sum_non_negative: assert property (@(posedge clk) disable iff (!rst_n)
    !sum_r[63] && (sum_r[62:52] != 11'h7FF))
    else $error("running sum is negative or not finite");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_r |-> cnt_r != '0)
    else $error("element count is zero within an open vector");

endmodule
